[src/bpq_pkg.sv]
// ---------------------------------------------------------------------------
// bpq_pkg: shared definitions for the bounded priority queue
// Request and status codes, controller/datapath command and status bundles,
// and the priority clamp used on insert.
// ---------------------------------------------------------------------------
`default_nettype none

package bpq_pkg;

  localparam int ValW = 32;
  localparam int PriW = 3;
  localparam int OccW = 5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [PriW-1:0] PRI_MIN = 3'd1;
  localparam logic [PriW-1:0] PRI_MAX = 3'd5;

  // Command from the controller to the datapath for one accepted word.
  typedef struct packed {
    logic load;    // a request was accepted; reload the result registers
    logic insert;  // insert into a queue that has room
    logic remove;  // remove from a queue that is not empty
  } bpq_cmd_t;

  // Queue status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
  } bpq_stat_t;

  // Out-of-range priorities saturate into the legal range.
  function automatic logic [PriW-1:0] clamp_priority(input logic [PriW-1:0] p);
    logic [PriW-1:0] r;
    if (p < PRI_MIN) begin
      r = PRI_MIN;
    end else if (p > PRI_MAX) begin
      r = PRI_MAX;
    end else begin
      r = p;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/bpq_ctrl.sv]
// ---------------------------------------------------------------------------
// bpq_ctrl: handshake controller
// Accepts request words, issues datapath commands, and owns the result
// valid flag and the status code of the pending result.
// ---------------------------------------------------------------------------
`default_nettype none

module bpq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_req_type,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  input  wire bpq_pkg::bpq_stat_t stat,
  output bpq_pkg::bpq_cmd_t       cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic       state_r, state_nxt;
  logic [1:0] status_r, status_nxt;
  logic       accept;

  // The result register may be reloaded in the cycle it is being drained.
  assign in_ready = (state_r == S_IDLE) || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.load   = accept;
    cmd.insert = accept && (in_req_type == bpq_pkg::REQ_INSERT) && !stat.full;
    cmd.remove = accept && (in_req_type == bpq_pkg::REQ_REMOVE) && !stat.empty;
  end

  always_comb begin
    status_nxt = status_r;
    if (accept) begin
      if ((in_req_type == bpq_pkg::REQ_INSERT) && stat.full) begin
        status_nxt = bpq_pkg::ST_OVERFLOW;
      end else if ((in_req_type == bpq_pkg::REQ_REMOVE) && stat.empty) begin
        status_nxt = bpq_pkg::ST_UNDERFLOW;
      end else begin
        status_nxt = bpq_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (accept) begin
          state_nxt = S_HOLD;
        end else if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid  = (state_r == S_HOLD);
  assign out_status = status_r;

endmodule

`default_nettype wire

[src/bpq_datapath.sv]
// ---------------------------------------------------------------------------
// bpq_datapath: sorted shift-register storage
// A row of cells kept in non-increasing priority order, slot 0 leaving
// next. Every cell compares against the new entry in parallel on insert and
// takes its neighbor's contents on remove.
// ---------------------------------------------------------------------------
`default_nettype none

module bpq_datapath #(
  parameter int DEPTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire bpq_pkg::bpq_cmd_t              cmd,
  input  wire logic signed [bpq_pkg::ValW-1:0] in_item_value,
  input  wire logic [bpq_pkg::PriW-1:0]       in_item_priority,
  output bpq_pkg::bpq_stat_t                  stat,
  output logic signed [bpq_pkg::ValW-1:0]     out_value,
  output logic [bpq_pkg::PriW-1:0]            out_priority,
  output logic [bpq_pkg::OccW-1:0]            out_occupancy
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [bpq_pkg::ValW-1:0] val_r [DEPTH];
  logic [bpq_pkg::ValW-1:0] val_nxt [DEPTH];
  logic [bpq_pkg::PriW-1:0] pri_r [DEPTH];
  logic [bpq_pkg::PriW-1:0] pri_nxt [DEPTH];
  logic [CntW-1:0]          cnt_r, cnt_nxt;
  logic [DEPTH-1:0]         keep;
  logic [DEPTH-1:0]         keep_prev;
  logic [bpq_pkg::PriW-1:0] new_pri;
  logic signed [bpq_pkg::ValW-1:0] res_val_r;
  logic [bpq_pkg::PriW-1:0]        res_pri_r;

  assign new_pri = bpq_pkg::clamp_priority(in_item_priority);

  // A held cell whose priority is at least the new one stays in place.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CntW'(i) < cnt_r) && (pri_r[i] >= new_pri);
    end
  end

  assign keep_prev = {keep[DEPTH-2:0], 1'b1};

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      val_nxt[i] = val_r[i];
      pri_nxt[i] = pri_r[i];
      if (cmd.insert && !keep[i]) begin
        if (keep_prev[i]) begin
          val_nxt[i] = in_item_value;
          pri_nxt[i] = new_pri;
        end else if (i > 0) begin
          val_nxt[i] = val_r[(i > 0) ? i - 1 : 0];
          pri_nxt[i] = pri_r[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd.remove && (i < DEPTH - 1)) begin
        val_nxt[i] = val_r[(i < DEPTH - 1) ? i + 1 : i];
        pri_nxt[i] = pri_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.insert) begin
      cnt_nxt = cnt_r + CntW'(1);
    end else if (cmd.remove) begin
      cnt_nxt = cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      val_r[i] <= val_nxt[i];
      pri_r[i] <= pri_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Result payload: the head cell on a successful remove, zeros otherwise.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (cmd.remove) begin
        res_val_r <= val_r[0];
        res_pri_r <= pri_r[0];
      end else begin
        res_val_r <= '0;
        res_pri_r <= '0;
      end
    end
  end

  assign stat.empty    = (cnt_r == '0);
  assign stat.full     = (cnt_r == CntW'(DEPTH));
  assign out_value     = res_val_r;
  assign out_priority  = res_pri_r;
  // The count changes only when a new result is loaded, so it tracks it.
  assign out_occupancy = bpq_pkg::OccW'(cnt_r);

endmodule

`default_nettype wire

[src/bounded_priority_queue_unit.sv]
// ---------------------------------------------------------------------------
// bounded_priority_queue_unit: bounded sorted-array priority queue
// Each request word either inserts a value with a priority of 1 to 5 or
// removes the highest-priority entry; ties leave in arrival order.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ channel carries one request word: in_req_type selects insert or
//   remove, in_item_value and in_item_priority describe the entry to insert.
//   Priorities 0, 6 and 7 saturate to 1 or 5. Every request produces exactly
//   one result word on the out_ channel: out_status (ok, overflow, underflow),
//   the removed value and priority (zero unless a remove succeeded) and
//   out_occupancy, the entry count after the request.
//   The result registers load at the edge that accepts a word. Throughput is
//   one word per cycle while the receiver keeps taking results; the figure is
//   set by the update of the cell row, where every cell compares against
//   the new priority in parallel and shifts by at most one place.
//   When the receiver stalls, the result stays in its output register and
//   in_ready drops until it is taken; in the cycle it is taken a new word is
//   accepted at the same time. Reset empties the queue and drops any pending
//   result; stored cells are not cleared, since only held slots are read.
// ---------------------------------------------------------------------------
`default_nettype none

module bounded_priority_queue_unit #(
  parameter int DEPTH = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_req_type,
  input  wire logic signed [bpq_pkg::ValW-1:0] in_item_value,
  input  wire logic [bpq_pkg::PriW-1:0]        in_item_priority,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [1:0]                           out_status,
  output logic signed [bpq_pkg::ValW-1:0]      out_value,
  output logic [bpq_pkg::PriW-1:0]             out_priority,
  output logic [bpq_pkg::OccW-1:0]             out_occupancy
);

  // Commands go from the controller to the cell row; the row reports
  // whether it is empty or full so that the controller can flag the
  // overflow and underflow cases and suppress the update.
  bpq_pkg::bpq_cmd_t  cmd;
  bpq_pkg::bpq_stat_t stat;

  bpq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_status  (out_status),
    .stat        (stat),
    .cmd         (cmd)
  );

  bpq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .stat             (stat),
    .out_value        (out_value),
    .out_priority     (out_priority),
    .out_occupancy    (out_occupancy)
  );

endmodule

`default_nettype wire

[tb/sv/bounded_priority_queue_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bounded_priority_queue_unit_test: self-checking bench for the priority queue
// Drives insert and remove words through the in_ channel and checks every
// out_ word against a sorted-array model of the queue held in the bench. The
// traffic fills the queue to overflow and drains it to underflow again and
// again, under several patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------

module bounded_priority_queue_unit_test;

  localparam int DEPTH = 16;

  // Number of random words sent in each idling phase.
  localparam int PHASE_WORDS = 440;

  // One expected result word, in the order of the out_ ports.
  typedef struct packed {
    logic [1:0]                      status;
    logic signed [bpq_pkg::ValW-1:0] value;
    logic [bpq_pkg::PriW-1:0]        prio;
    logic [bpq_pkg::OccW-1:0]        occupancy;
  } queue_result_t;

  // Keeps a copy of the queue contents, works out the result of every
  // accepted request word and holds those results until the block
  // delivers them.
  class pq_result_tracker;
    logic signed [bpq_pkg::ValW-1:0] held_value [DEPTH];
    logic [bpq_pkg::PriW-1:0]        held_prio [DEPTH];
    int                              held_count;
    queue_result_t                   awaited [$];
    int                              mismatch_count;

    function new();
      held_count     = 0;
      mismatch_count = 0;
    endfunction

    // Applies one accepted request word to the queue copy.
    function void note_request(logic req, logic signed [bpq_pkg::ValW-1:0] value,
                               logic [bpq_pkg::PriW-1:0] prio);
      queue_result_t            r;
      logic [bpq_pkg::PriW-1:0] pr;
      int                       pos;
      int                       i;
      r = '0;
      r.status = bpq_pkg::ST_OK;
      if (req == bpq_pkg::REQ_INSERT) begin
        if (held_count >= DEPTH) begin
          r.status = bpq_pkg::ST_OVERFLOW;
        end else begin
          // Priorities outside 1..5 saturate to the nearer end.
          if (prio == 3'd0) begin
            pr = bpq_pkg::PRI_MIN;
          end else if (prio > bpq_pkg::PRI_MAX) begin
            pr = bpq_pkg::PRI_MAX;
          end else begin
            pr = prio;
          end
          // A new entry lands behind every entry of equal or higher
          // priority, so ties leave in arrival order.
          pos = 0;
          while (pos < held_count && held_prio[pos] >= pr) begin
            pos++;
          end
          for (i = held_count; i > pos; i--) begin
            held_value[i] = held_value[i-1];
            held_prio[i]  = held_prio[i-1];
          end
          held_value[pos] = value;
          held_prio[pos]  = pr;
          held_count++;
        end
      end else begin
        if (held_count == 0) begin
          r.status = bpq_pkg::ST_UNDERFLOW;
        end else begin
          r.value = held_value[0];
          r.prio  = held_prio[0];
          for (i = 1; i < held_count; i++) begin
            held_value[i-1] = held_value[i];
            held_prio[i-1]  = held_prio[i];
          end
          held_count--;
        end
      end
      r.occupancy = held_count[bpq_pkg::OccW-1:0];
      awaited.push_back(r);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      if (mismatch_count < 40) begin
        $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatch_count++;
    endtask

    // Compares one delivered result word with the oldest expectation.
    task check_result(logic [1:0] status, logic signed [bpq_pkg::ValW-1:0] value,
                      logic [bpq_pkg::PriW-1:0] prio,
                      logic [bpq_pkg::OccW-1:0] occupancy);
      queue_result_t want;
      if (awaited.size() == 0) begin
        report_mismatch("unexpected result word, status", status, 0);
      end else begin
        want = awaited.pop_front();
        if (status !== want.status) begin
          report_mismatch("status", status, want.status);
        end
        if (value !== want.value) begin
          report_mismatch("value", value, want.value);
        end
        if (prio !== want.prio) begin
          report_mismatch("priority", prio, want.prio);
        end
        if (occupancy !== want.occupancy) begin
          report_mismatch("occupancy", occupancy, want.occupancy);
        end
      end
    endtask
  endclass

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic                            in_req_type = bpq_pkg::REQ_INSERT;
  logic signed [bpq_pkg::ValW-1:0] in_item_value = '0;
  logic [bpq_pkg::PriW-1:0]        in_item_priority = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [1:0]                      out_status;
  logic signed [bpq_pkg::ValW-1:0] out_value;
  logic [bpq_pkg::PriW-1:0]        out_priority;
  logic [bpq_pkg::OccW-1:0]        out_occupancy;

  pq_result_tracker tracker;

  // Idling of the two sides, in percent of cycles; the stimulus sets them
  // per phase.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;

  // Long receiver hold-offs: the stimulus raises the request count and the
  // receiver process serves each request with a stretch of its own.
  int hold_off_requests = 0;
  int hold_off_served = 0;
  int stall_left = 0;

  bounded_priority_queue_unit #(
    .DEPTH(DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_item_value   (in_item_value),
    .in_item_priority(in_item_priority),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_value       (out_value),
    .out_priority    (out_priority),
    .out_occupancy   (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Values lean on the sign extremes, zero, minus one and small numbers,
  // with plenty of full-width noise so that every bit toggles.
  function automatic logic signed [bpq_pkg::ValW-1:0] random_value();
    logic signed [bpq_pkg::ValW-1:0] v;
    case ($urandom_range(9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2: v = '0;
      3: v = -1;
      4, 5: v = $urandom_range(255);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly legal priorities; now and then any 3-bit code, so that the
  // saturating cases 0, 6 and 7 keep showing up.
  function automatic logic [bpq_pkg::PriW-1:0] random_priority();
    logic [bpq_pkg::PriW-1:0] p;
    if ($urandom_range(99) < 15) begin
      p = bpq_pkg::PriW'($urandom_range(7));
    end else begin
      p = bpq_pkg::PriW'($urandom_range(5, 1));
    end
    return p;
  endfunction

  // Offers one request word and returns at the edge where it is accepted.
  // It is called at a rising edge; idle cycles come first so that a word
  // that follows directly keeps in_valid high without a drop.
  task automatic send_request(input logic req,
                              input logic signed [bpq_pkg::ValW-1:0] value,
                              input logic [bpq_pkg::PriW-1:0] prio);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_req_type      <= req;
    in_item_value    <= value;
    in_item_priority <= prio;
    do begin
      @(posedge clk);
    end while (!in_ready);
    tracker.note_request(req, value, prio);
  endtask

  // Receiver: takes result words, checks them and drives out_ready. The
  // handshake is judged on the values from before the edge, and out_ready
  // gets exactly one assignment per edge out of reset.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        tracker.check_result(out_status, out_value, out_priority, out_occupancy);
      end
      if (hold_off_requests != hold_off_served) begin
        hold_off_served = hold_off_served + 1;
        stall_left = 60 + $urandom_range(40);
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  initial begin : stimulus
    int  phase;
    int  n;
    int  fill_bias_pct;
    logic req;
    tracker = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling. A remove from the empty queue comes first,
    // then seventeen inserts: sign extremes and every priority code,
    // including the ones that saturate and repeats that make ties. The last
    // insert finds the queue full. Seven removes follow and show the order.
    send_request(bpq_pkg::REQ_REMOVE, 32'sh7fff_ffff, 3'd7);
    for (n = 0; n < DEPTH + 1; n++) begin
      case (n)
        0: send_request(bpq_pkg::REQ_INSERT, 32'sh8000_0000, bpq_pkg::PriW'(n % 8));
        1: send_request(bpq_pkg::REQ_INSERT, 32'sh7fff_ffff, bpq_pkg::PriW'(n % 8));
        2: send_request(bpq_pkg::REQ_INSERT, -1, bpq_pkg::PriW'(n % 8));
        3: send_request(bpq_pkg::REQ_INSERT, '0, bpq_pkg::PriW'(n % 8));
        default: send_request(bpq_pkg::REQ_INSERT, $urandom, bpq_pkg::PriW'(n % 8));
      endcase
    end
    for (n = 0; n < 7; n++) begin
      send_request(bpq_pkg::REQ_REMOVE, random_value(), random_priority());
    end

    // Random part in four idling phases. Every forty words the mix of
    // inserts and removes swings between filling and draining, so the queue
    // keeps running into overflow and underflow with random contents.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 0;
          // With the receiver held off the output register stays full and
          // the block has to refuse the words that keep coming.
          hold_off_requests <= hold_off_requests + 1;
        end
        1: begin
          sender_idle_pct    = 73;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct    = 0;
          receiver_stall_pct = 73;
        end
        default: begin
          sender_idle_pct    = 28;
          receiver_stall_pct = 28;
        end
      endcase
      fill_bias_pct = 50;
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n % 40 == 0) begin
          case ($urandom_range(2))
            0: fill_bias_pct = 90;
            1: fill_bias_pct = 50;
            default: fill_bias_pct = 10;
          endcase
        end
        req = ($urandom_range(99) < fill_bias_pct) ? bpq_pkg::REQ_INSERT
                                                   : bpq_pkg::REQ_REMOVE;
        send_request(req, random_value(), random_priority());
      end
    end
    in_valid <= 1'b0;

    // Let the last result words drain, then give the block a few more edges
    // in which nothing may arrive.
    while (tracker.awaited.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // A run of this size ends well before this bound even with the slowest
  // idling; if it has not, the run is reported as failed.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
